@@ rtl/rpmc_pkg.sv @@
package rpmc_pkg;

  localparam int DataW     = 24;
  localparam int IdxW      = 14;
  localparam int CfgW      = 15;
  localparam int OutW      = 32;
  localparam int MaxPoints = 16384;

  localparam int Lanes = 4;
  localparam int ProdW = 2 * DataW;
  localparam int SumW  = ProdW + 1;
  localparam int MagW  = ProdW;
  localparam int SqW   = ProdW;
  localparam int DenW  = ProdW;
  localparam int XW    = 64;
  localparam int RootW = 32;
  localparam int QW    = 33;

  localparam int ShQual    = 30;
  localparam int ShEcc     = 16;
  localparam int RootSteps = 32;
  localparam int DivSteps  = QW;

  localparam logic [SqW-1:0]  RefMinSq = SqW'(18);
  localparam logic [DenW-1:0] UnitDen  = DenW'(256);

  // numerators (sign/magnitude) and divisor source, front end to root stage
  typedef struct packed {
    logic [Lanes-1:0][MagW-1:0] mag;
    logic [Lanes-1:0]           neg;
    logic [SqW-1:0]             sq;
    logic                       qmode;
    logic                       uzero;
    logic                       ref_low;
    logic                       last;
  } num_t;

  typedef struct packed {
    logic [Lanes-1:0] neg;
    logic [RootW-1:0] m;
    logic             qmode;
    logic             ref_low;
    logic             last;
  } side_t;

  typedef struct packed {
    logic signed [OutW-1:0] sup_re;
    logic signed [OutW-1:0] sup_im;
    logic signed [OutW-1:0] unsup_re;
    logic signed [OutW-1:0] unsup_im;
    logic                   last;
    logic                   qmode;
    logic                   ref_low;
  } res_t;

  // signed saturation of a rounded quotient magnitude
  function automatic logic signed [OutW-1:0] sat_mag(input logic neg, input logic [QW:0] q,
                                                     input logic big);
    logic over;
    over = big | q[QW] | q[QW-1] | q[OutW-1];
    if (neg) begin
      sat_mag = over ? {1'b1, {(OutW-1){1'b0}}} : -q[OutW-1:0];
    end else begin
      sat_mag = over ? {1'b0, {(OutW-1){1'b1}}} : q[OutW-1:0];
    end
  endfunction

endpackage

@@ rtl/reference_phase_magnitude_correction.sv @@
// Reference phase and magnitude correction, one complex point per beat.
//
// Input channel (in_valid_i/in_ready_o): one beat carries a suppressed point,
// an unsuppressed point, a Q1.22 reference point, the point index and a last
// flag. Points with index below quality_points are divided by the reference
// (all-zero result when the reference is near zero); the rest get eddy
// current correction against the unsuppressed phase.
// Output channel (out_valid_o/out_ready_i): one result beat per input beat,
// Q24.8 saturating, in order, last_out_o copied from last_in_i.
// Throughput: one beat per cycle unless the output stalls. Stages: 4 front,
// the 32-stage square root (one root bit per stage), the 33-stage divider
// (one quotient bit per stage), then rounding/saturation.
// Reset clears all stage valid bits and quality_points. The user must write
// quality_points via quality_points_we_i only while idle; not enforced here.
// Stall: when a result waits and out_ready_i is low, the whole pipeline
// holds; in_ready_o drops in that cycle, so no beat is lost or repeated.
module reference_phase_magnitude_correction import rpmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] sup_re_i,
  input  logic signed [DataW-1:0] sup_im_i,
  input  logic signed [DataW-1:0] unsup_re_i,
  input  logic signed [DataW-1:0] unsup_im_i,
  input  logic signed [DataW-1:0] ref_re_i,
  input  logic signed [DataW-1:0] ref_im_i,
  input  logic [IdxW-1:0]         point_index_i,
  input  logic                    last_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OutW-1:0]  sup_out_re_o,
  output logic signed [OutW-1:0]  sup_out_im_o,
  output logic signed [OutW-1:0]  unsup_out_re_o,
  output logic signed [OutW-1:0]  unsup_out_im_o,
  output logic                    last_out_o,
  input  logic                    quality_points_we_i,
  input  logic [CfgW-1:0]         quality_points_wdata_i
);

  logic [CfgW-1:0] qp_q;
  logic            en;
  logic            fr_valid, sq_valid;
  num_t            fr_num, sq_num;
  logic [RootW-1:0] sq_root;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qp_q <= '0;
    end else if (quality_points_we_i) begin
      qp_q <= quality_points_wdata_i;
    end
  end

  // global advance: the last stage is the output register
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rpmc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (in_valid_i),
    .sup_re_i         (sup_re_i),
    .sup_im_i         (sup_im_i),
    .unsup_re_i       (unsup_re_i),
    .unsup_im_i       (unsup_im_i),
    .ref_re_i         (ref_re_i),
    .ref_im_i         (ref_im_i),
    .point_index_i    (point_index_i),
    .last_i           (last_in_i),
    .quality_points_i (qp_q),
    .valid_o          (fr_valid),
    .num_o            (fr_num)
  );

  rpmc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (fr_num),
    .valid_o (sq_valid),
    .num_o   (sq_num),
    .root_o  (sq_root)
  );

  rpmc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (sq_num),
    .root_i  (sq_root),
    .valid_o (out_valid_o),
    .res_o   (res)
  );

  assign sup_out_re_o   = res.sup_re;
  assign sup_out_im_o   = res.sup_im;
  assign unsup_out_re_o = res.unsup_re;
  assign unsup_out_im_o = res.unsup_im;
  assign last_out_o     = res.last;

  // eddy-current results put u on the non-negative real axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !res.qmode |-> unsup_out_im_o == '0 && !unsup_out_re_o[OutW-1])
    else $error("ecc result off the real axis");

  // small-reference guard only exists on the deconvolution path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res.ref_low |-> res.qmode)
    else $error("small reference flag outside deconvolution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res.ref_low |-> sup_out_re_o == '0 && sup_out_im_o == '0 &&
                                   unsup_out_re_o == '0 && unsup_out_im_o == '0)
    else $error("small reference result not zero");

endmodule

@@ rtl/rpmc_front.sv @@
module rpmc_front import rpmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] sup_re_i,
  input  logic signed [DataW-1:0] sup_im_i,
  input  logic signed [DataW-1:0] unsup_re_i,
  input  logic signed [DataW-1:0] unsup_im_i,
  input  logic signed [DataW-1:0] ref_re_i,
  input  logic signed [DataW-1:0] ref_im_i,
  input  logic [IdxW-1:0]         point_index_i,
  input  logic                    last_i,
  input  logic [CfgW-1:0]         quality_points_i,
  output logic                    valid_o,
  output num_t                    num_o
);

  logic [3:0] v_q;

  logic [CfgW-1:0]         limit;
  logic                    qmode_d;
  logic signed [DataW-1:0] cr_d, ci_d;

  // stage 1: operands
  logic signed [DataW-1:0] s1_sr_q, s1_si_q, s1_ur_q, s1_ui_q, s1_cr_q, s1_ci_q;
  logic                    s1_qmode_q, s1_last_q;
  // stage 2: products
  logic signed [ProdW-1:0] p_q [10];
  logic signed [DataW-1:0] s2_sr_q, s2_si_q;
  logic                    s2_qmode_q, s2_uzero_q, s2_last_q;
  // stage 3: sums
  logic signed [SumW-1:0]  n_q [Lanes];
  logic [SqW-1:0]          s3_sq_q;
  logic                    s3_qmode_q, s3_uzero_q, s3_last_q;
  // stage 4: sign/magnitude
  num_t                    num_q;

  always_comb begin
    limit   = (quality_points_i > CfgW'(MaxPoints)) ? CfgW'(MaxPoints) : quality_points_i;
    qmode_d = {1'b0, point_index_i} < limit;
    cr_d    = qmode_d ? ref_re_i : unsup_re_i;
    ci_d    = qmode_d ? ref_im_i : unsup_im_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sr_q    <= sup_re_i;
      s1_si_q    <= sup_im_i;
      s1_ur_q    <= unsup_re_i;
      s1_ui_q    <= unsup_im_i;
      s1_cr_q    <= cr_d;
      s1_ci_q    <= ci_d;
      s1_qmode_q <= qmode_d;
      s1_last_q  <= last_i;

      p_q[0]     <= s1_sr_q * s1_cr_q;
      p_q[1]     <= s1_si_q * s1_ci_q;
      p_q[2]     <= s1_si_q * s1_cr_q;
      p_q[3]     <= s1_sr_q * s1_ci_q;
      p_q[4]     <= s1_ur_q * s1_cr_q;
      p_q[5]     <= s1_ui_q * s1_ci_q;
      p_q[6]     <= s1_ui_q * s1_cr_q;
      p_q[7]     <= s1_ur_q * s1_ci_q;
      p_q[8]     <= s1_cr_q * s1_cr_q;
      p_q[9]     <= s1_ci_q * s1_ci_q;
      s2_sr_q    <= s1_sr_q;
      s2_si_q    <= s1_si_q;
      s2_qmode_q <= s1_qmode_q;
      s2_uzero_q <= !s1_qmode_q && (s1_cr_q == '0) && (s1_ci_q == '0);
      s2_last_q  <= s1_last_q;

      // zero unsuppressed point: pass s through, divided later by 256
      n_q[0]     <= s2_uzero_q ? SumW'(s2_sr_q) : SumW'(p_q[0]) + SumW'(p_q[1]);
      n_q[1]     <= s2_uzero_q ? SumW'(s2_si_q) : SumW'(p_q[2]) - SumW'(p_q[3]);
      n_q[2]     <= SumW'(p_q[4]) + SumW'(p_q[5]);
      n_q[3]     <= SumW'(p_q[6]) - SumW'(p_q[7]);
      s3_sq_q    <= SqW'($unsigned(p_q[8])) + SqW'($unsigned(p_q[9]));
      s3_qmode_q <= s2_qmode_q;
      s3_uzero_q <= s2_uzero_q;
      s3_last_q  <= s2_last_q;

      for (int l = 0; l < Lanes; l++) begin
        num_q.neg[l] <= n_q[l][SumW-1];
        num_q.mag[l] <= n_q[l][SumW-1] ? MagW'(-n_q[l]) : MagW'(n_q[l]);
      end
      num_q.sq      <= s3_sq_q;
      num_q.qmode   <= s3_qmode_q;
      num_q.uzero   <= s3_uzero_q;
      num_q.ref_low <= s3_qmode_q && (s3_sq_q < RefMinSq);
      num_q.last    <= s3_last_q;
    end
  end

  assign valid_o = v_q[3];
  assign num_o   = num_q;

endmodule

@@ rtl/rpmc_sqrt.sv @@
module rpmc_sqrt import rpmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  num_t             num_i,
  output logic             valid_o,
  output num_t             num_o,
  output logic [RootW-1:0] root_o
);

  logic [RootSteps+1:0] v_q;
  num_t                 num_q [RootSteps+2];
  logic [XW-1:0]        x_q   [RootSteps+1];
  logic [XW-1:0]        res_q [RootSteps+1];
  logic [XW-1:0]        x_d   [RootSteps+1];
  logic [XW-1:0]        res_d [RootSteps+1];
  logic [XW-1:0]        bit_w [RootSteps+1];
  logic [XW:0]          sum_w [RootSteps+1];
  logic [RootW-1:0]     m_d, m_q;

  // one result bit per stage, radix-2 digit recurrence
  always_comb begin
    x_d[0]   = {num_i.sq, {(XW-SqW){1'b0}}};
    res_d[0] = '0;
    bit_w[0] = '0;
    sum_w[0] = '0;
    for (int k = 1; k <= RootSteps; k++) begin
      bit_w[k] = XW'(1) << (XW - 2 * k);
      sum_w[k] = {1'b0, res_q[k-1]} + {1'b0, bit_w[k]};
      if ({1'b0, x_q[k-1]} >= sum_w[k]) begin
        x_d[k]   = x_q[k-1] - sum_w[k][XW-1:0];
        res_d[k] = (res_q[k-1] >> 1) + bit_w[k];
      end else begin
        x_d[k]   = x_q[k-1];
        res_d[k] = res_q[k-1] >> 1;
      end
    end
    // round to nearest
    m_d = (x_q[RootSteps] > res_q[RootSteps]) ? RootW'(res_q[RootSteps] + XW'(1))
                                              : RootW'(res_q[RootSteps]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RootSteps:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num_i;
      for (int k = 0; k <= RootSteps; k++) begin
        x_q[k]   <= x_d[k];
        res_q[k] <= res_d[k];
      end
      for (int k = 1; k <= RootSteps + 1; k++) begin
        num_q[k] <= num_q[k-1];
      end
      m_q <= m_d;
    end
  end

  assign valid_o = v_q[RootSteps+1];
  assign num_o   = num_q[RootSteps+1];
  assign root_o  = m_q;

endmodule

@@ rtl/rpmc_div.sv @@
module rpmc_div import rpmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  num_t             num_i,
  input  logic [RootW-1:0] root_i,
  output logic             valid_o,
  output res_t             res_o
);

  logic [DivSteps+2:0] v_q;
  side_t               side_q [DivSteps+2];
  logic [DenW-1:0]     den_q  [DivSteps+1];
  logic [DenW-1:0]     r_q    [DivSteps+1][Lanes];
  logic [QW-1:0]       low_q  [DivSteps+1][Lanes];
  logic [QW-1:0]       q_q    [DivSteps+1][Lanes];
  logic [Lanes-1:0]    ov_q   [DivSteps+1];

  logic [DenW-1:0]     den_d;
  logic [DenW-1:0]     r_d    [DivSteps+1][Lanes];
  logic [QW-1:0]       low_d  [DivSteps+1][Lanes];
  logic [QW-1:0]       q_d    [DivSteps+1][Lanes];
  logic [Lanes-1:0]    ov_d;
  logic [DenW:0]       rr_w   [DivSteps+1][Lanes];
  logic [DenW:0]       rs_w   [DivSteps+1][Lanes];
  logic [DenW:0]       rnd2_w [Lanes];

  logic [QW:0]         qr_q   [Lanes];
  logic [Lanes-1:0]    big_q;
  res_t                res_q, res_d;

  always_comb begin
    // numerator is mag * 2^sh; its part above the quotient bits seeds the remainder
    den_d = num_i.qmode ? num_i.sq : (num_i.uzero ? UnitDen : DenW'(root_i));
    for (int l = 0; l < Lanes; l++) begin
      if (num_i.qmode) begin
        r_d[0][l]   = num_i.mag[l] >> (QW - ShQual);
        low_d[0][l] = QW'(num_i.mag[l] << ShQual);
      end else begin
        r_d[0][l]   = num_i.mag[l] >> (QW - ShEcc);
        low_d[0][l] = QW'(num_i.mag[l] << ShEcc);
      end
      q_d[0][l]  = '0;
      ov_d[l]    = r_d[0][l] >= den_d;
      rr_w[0][l] = '0;
      rs_w[0][l] = '0;
    end
    // restoring division, one quotient bit per stage
    for (int k = 1; k <= DivSteps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        rr_w[k][l] = {r_q[k-1][l], low_q[k-1][l][QW-1]};
        rs_w[k][l] = rr_w[k][l] - {1'b0, den_q[k-1]};
        if (rr_w[k][l] >= {1'b0, den_q[k-1]}) begin
          r_d[k][l] = rs_w[k][l][DenW-1:0];
          q_d[k][l] = {q_q[k-1][l][QW-2:0], 1'b1};
        end else begin
          r_d[k][l] = rr_w[k][l][DenW-1:0];
          q_d[k][l] = {q_q[k-1][l][QW-2:0], 1'b0};
        end
        low_d[k][l] = low_q[k-1][l] << 1;
      end
    end
    for (int l = 0; l < Lanes; l++) begin
      rnd2_w[l] = {r_q[DivSteps][l], 1'b0};
    end
  end

  always_comb begin
    res_d.sup_re   = sat_mag(side_q[DivSteps+1].neg[0], qr_q[0], big_q[0]);
    res_d.sup_im   = sat_mag(side_q[DivSteps+1].neg[1], qr_q[1], big_q[1]);
    res_d.unsup_re = sat_mag(side_q[DivSteps+1].neg[2], qr_q[2], big_q[2]);
    res_d.unsup_im = sat_mag(side_q[DivSteps+1].neg[3], qr_q[3], big_q[3]);
    res_d.last     = side_q[DivSteps+1].last;
    res_d.qmode    = side_q[DivSteps+1].qmode;
    res_d.ref_low  = side_q[DivSteps+1].ref_low;
    if (!side_q[DivSteps+1].qmode) begin
      // eddy-current case: u becomes its magnitude on the real axis
      res_d.unsup_re = sat_mag(1'b0, (QW+1)'(side_q[DivSteps+1].m), 1'b0);
      res_d.unsup_im = '0;
    end
    if (side_q[DivSteps+1].ref_low) begin
      res_d.sup_re   = '0;
      res_d.sup_im   = '0;
      res_d.unsup_re = '0;
      res_d.unsup_im = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps+1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0].neg     <= num_i.neg;
      side_q[0].m       <= root_i;
      side_q[0].qmode   <= num_i.qmode;
      side_q[0].ref_low <= num_i.ref_low;
      side_q[0].last    <= num_i.last;
      den_q[0]          <= den_d;
      ov_q[0]           <= ov_d;
      for (int k = 1; k <= DivSteps + 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 1; k <= DivSteps; k++) begin
        den_q[k] <= den_q[k-1];
        ov_q[k]  <= ov_q[k-1];
      end
      for (int k = 0; k <= DivSteps; k++) begin
        for (int l = 0; l < Lanes; l++) begin
          r_q[k][l]   <= r_d[k][l];
          low_q[k][l] <= low_d[k][l];
          q_q[k][l]   <= q_d[k][l];
        end
      end
      // round half away from zero on the magnitude
      for (int l = 0; l < Lanes; l++) begin
        qr_q[l] <= {1'b0, q_q[DivSteps][l]}
                   + (QW+1)'(rnd2_w[l] >= {1'b0, den_q[DivSteps]});
      end
      big_q <= ov_q[DivSteps];
      res_q <= res_d;
    end
  end

  assign valid_o = v_q[DivSteps+2];
  assign res_o   = res_q;

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpmc_pkg::*;

  // one input beat: a point of each record, the reference and its position
  typedef struct {
    logic signed [DataW-1:0] sup_re;
    logic signed [DataW-1:0] sup_im;
    logic signed [DataW-1:0] unsup_re;
    logic signed [DataW-1:0] unsup_im;
    logic signed [DataW-1:0] ref_re;
    logic signed [DataW-1:0] ref_im;
    logic [IdxW-1:0]         idx;
    logic                    last;
  } point_t;

  // one corrected output beat
  typedef struct {
    logic signed [OutW-1:0] sup_re;
    logic signed [OutW-1:0] sup_im;
    logic signed [OutW-1:0] unsup_re;
    logic signed [OutW-1:0] unsup_im;
    logic                   last;
  } corr_t;

  localparam longint unsigned QuotCap = 64'd4294967296;
  localparam int DrainCycles = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DataW-1:0] sup_re_i = '0, sup_im_i = '0;
  logic signed [DataW-1:0] unsup_re_i = '0, unsup_im_i = '0;
  logic signed [DataW-1:0] ref_re_i = '0, ref_im_i = '0;
  logic [IdxW-1:0] point_index_i = '0;
  logic last_in_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OutW-1:0] sup_out_re_o, sup_out_im_o, unsup_out_re_o, unsup_out_im_o;
  logic last_out_o;
  logic quality_points_we_i = 1'b0;
  logic [CfgW-1:0] quality_points_wdata_i = '0;

  reference_phase_magnitude_correction uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .sup_re_i, .sup_im_i, .unsup_re_i, .unsup_im_i,
    .ref_re_i, .ref_im_i, .point_index_i, .last_in_i,
    .out_valid_o, .out_ready_i,
    .sup_out_re_o, .sup_out_im_o, .unsup_out_re_o, .unsup_out_im_o, .last_out_o,
    .quality_points_we_i, .quality_points_wdata_i
  );

  point_t pending_points[$];   // beats waiting to be driven
  corr_t  corrected_q[$];      // predicted results, oldest first
  int unsigned qp_shadow = 0;  // our copy of quality_points
  int errors = 0;
  bit no_idle = 1'b0;          // final phase runs at full rate on both sides
  int send_gap = 0;
  int sink_stall = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // round(n * 2^sh / d), ties away from zero, capped at 2^32
  function automatic longint unsigned div_round(longint unsigned n, int sh,
                                                longint unsigned d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q >= QuotCap) return QuotCap;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        q++;
        r -= d;
      end
      if (q >= QuotCap) return QuotCap;
    end
    if (2 * r >= d) q++;
    return (q < QuotCap) ? q : QuotCap;
  endfunction

  function automatic logic signed [OutW-1:0] clip32(bit neg, longint unsigned m);
    if (neg) return (m >= 64'd2147483648) ? 32'sh8000_0000 : -m[OutW-1:0];
    return (m > 64'd2147483647) ? 32'sh7fff_ffff : m[OutW-1:0];
  endfunction

  function automatic logic signed [OutW-1:0] scaled_div(longint num, int sh,
                                                        longint unsigned den);
    longint unsigned mag;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    return clip32(num < 0, div_round(mag, sh, den));
  endfunction

  // nearest integer to sqrt(x)
  function automatic longint unsigned root_round(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return (x > res) ? res + 1 : res;
  endfunction

  function automatic corr_t correct_point(point_t p, int unsigned qp);
    longint sr, si, ur, ui, rr, ri;
    longint unsigned lim, den, uu, m;
    corr_t c;
    sr = longint'(p.sup_re);   si = longint'(p.sup_im);
    ur = longint'(p.unsup_re); ui = longint'(p.unsup_im);
    rr = longint'(p.ref_re);   ri = longint'(p.ref_im);
    lim = 64'((qp > MaxPoints) ? MaxPoints : qp);
    c.last = p.last;
    if (p.idx < lim) begin
      // deconvolution by the reference
      den = rr * rr + ri * ri;
      if (den < 18) begin
        c.sup_re = '0; c.sup_im = '0; c.unsup_re = '0; c.unsup_im = '0;
      end else begin
        c.sup_re   = scaled_div(sr * rr + si * ri, ShQual, den);
        c.sup_im   = scaled_div(si * rr - sr * ri, ShQual, den);
        c.unsup_re = scaled_div(ur * rr + ui * ri, ShQual, den);
        c.unsup_im = scaled_div(ui * rr - ur * ri, ShQual, den);
      end
    end else begin
      // eddy current correction against the unsuppressed phase
      uu = ur * ur + ui * ui;
      if (uu == 0) begin
        c.sup_re = OutW'(sr * 256);
        c.sup_im = OutW'(si * 256);
        c.unsup_re = '0;
        c.unsup_im = '0;
      end else begin
        m = root_round(uu << 16);
        c.sup_re   = scaled_div(sr * ur + si * ui, ShEcc, m);
        c.sup_im   = scaled_div(si * ur - sr * ui, ShEcc, m);
        c.unsup_re = clip32(1'b0, m);
        c.unsup_im = '0;
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [DataW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return DataW'($signed($urandom_range(0, 8)) - 4);
      3: return DataW'($signed($urandom_range(0, 8192)) - 4096);
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point(int unsigned qp);
    point_t p;
    int unsigned lim;
    p.sup_re = rand_word();
    p.sup_im = rand_word();
    p.unsup_re = rand_word();
    p.unsup_im = rand_word();
    if ($urandom_range(0, 7) == 0) begin
      p.unsup_re = '0;
      p.unsup_im = '0;
    end
    case ($urandom_range(0, 5))
      0: begin  // near-zero reference, both sides of the guard
        p.ref_re = DataW'($signed($urandom_range(0, 10)) - 5);
        p.ref_im = DataW'($signed($urandom_range(0, 10)) - 5);
      end
      1, 2: begin  // roughly unit magnitude
        p.ref_re = DataW'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
        p.ref_im = DataW'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
      end
      default: begin
        p.ref_re = rand_word();
        p.ref_im = rand_word();
      end
    endcase
    lim = (qp > MaxPoints) ? MaxPoints : qp;
    // straddle the mode boundary most of the time
    if (lim > 0 && $urandom_range(0, 1) == 0)
      p.idx = IdxW'($urandom_range(0, lim - 1));
    else if (lim > 0 && lim < MaxPoints && $urandom_range(0, 2) == 0)
      p.idx = IdxW'(lim + $urandom_range(0, 3));
    else
      p.idx = IdxW'($urandom);
    p.last = $urandom_range(0, 15) == 0;
    return p;
  endfunction

  function automatic point_t mk_point(int sr, int si, int ur, int ui, int rr, int ri,
                                      int idx, bit last);
    point_t p;
    p.sup_re = DataW'(sr);   p.sup_im = DataW'(si);
    p.unsup_re = DataW'(ur); p.unsup_im = DataW'(ui);
    p.ref_re = DataW'(rr);   p.ref_im = DataW'(ri);
    p.idx = IdxW'(idx);
    p.last = last;
    return p;
  endfunction

  // register writes only happen with nothing in flight
  task automatic drain();
    while (pending_points.size() != 0 || in_valid_i || corrected_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_qp(int unsigned v);
    @(posedge clk_i);
    quality_points_we_i <= 1'b1;
    quality_points_wdata_i <= CfgW'(v);
    qp_shadow = v;
    @(posedge clk_i);
    quality_points_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned qp, int n);
    drain();
    write_qp(qp);
    for (int i = 0; i < n; i++) pending_points.push_back(rand_point(qp));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops pending beats, inserts idle bursts between beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_ready_o)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 5);
        in_valid_i <= 1'b0;
      end else if (pending_points.size() != 0) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid_i <= 1'b1;
        sup_re_i <= p.sup_re;     sup_im_i <= p.sup_im;
        unsup_re_i <= p.unsup_re; unsup_im_i <= p.unsup_im;
        ref_re_i <= p.ref_re;     ref_im_i <= p.ref_im;
        point_index_i <= p.idx;
        last_in_i <= p.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      sink_stall <= $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted input beats, check accepted output beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      point_t p;
      p.sup_re = sup_re_i;     p.sup_im = sup_im_i;
      p.unsup_re = unsup_re_i; p.unsup_im = unsup_im_i;
      p.ref_re = ref_re_i;     p.ref_im = ref_im_i;
      p.idx = point_index_i;
      p.last = last_in_i;
      corrected_q.push_back(correct_point(p, qp_shadow));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corrected_q.size() == 0) begin
        report_mismatch("unexpected output beat", 1, 0);
      end else begin
        corr_t c;
        c = corrected_q.pop_front();
        if (sup_out_re_o !== c.sup_re) report_mismatch("sup_out_re", sup_out_re_o, c.sup_re);
        if (sup_out_im_o !== c.sup_im) report_mismatch("sup_out_im", sup_out_im_o, c.sup_im);
        if (unsup_out_re_o !== c.unsup_re)
          report_mismatch("unsup_out_re", unsup_out_re_o, c.unsup_re);
        if (unsup_out_im_o !== c.unsup_im)
          report_mismatch("unsup_out_im", unsup_out_im_o, c.unsup_im);
        if (last_out_o !== c.last) report_mismatch("last_out", last_out_o, c.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value: pure eddy current correction
    // zero unsuppressed point, extremes, tiny u
    pending_points.push_back(mk_point(8388607, -8388608, 0, 0, 0, 0, 0, 0));
    pending_points.push_back(mk_point(-8388608, -8388608, -8388608, -8388608, 0, 0, 16383, 1));
    pending_points.push_back(mk_point(8388607, 8388607, 1, 0, 0, 0, 5, 0));
    pending_points.push_back(mk_point(-8388608, 8388607, 0, -1, 1, 1, 7, 0));
    pending_points.push_back(mk_point(1000, -2000, 3, 4, 0, 0, 0, 1));
    pending_points.push_back(mk_point(0, 0, 8388607, 8388607, 0, 0, 100, 0));
    drain();

    // oversized register acts as every point deconvolved
    write_qp(32767);
    pending_points.push_back(mk_point(1000, 2000, 3000, 4000, 0, 0, 16383, 0));     // zero ref
    pending_points.push_back(mk_point(1000, 2000, 3000, 4000, 4, 1, 1, 0));         // just below guard
    pending_points.push_back(mk_point(1000, 2000, 3000, 4000, 3, 3, 2, 0));         // at guard
    pending_points.push_back(mk_point(8388607, -8388608, 8388607, 8388607, 1, 0, 3, 1));
    pending_points.push_back(mk_point(-8388608, -8388608, -8388608, 0, -8388608, -8388608,
                                      16383, 0));
    pending_points.push_back(mk_point(123456, -654321, 77, -88, 4194304, 0, 10, 0));
    pending_points.push_back(mk_point(-5, 7, 8388607, -8388608, 0, -4194304, 11, 1));
    pending_points.push_back(mk_point(8388607, 8388607, 0, 0, 8388607, 8388607, 12, 0));
    drain();

    // maximum in range, then a small boundary
    write_qp(MaxPoints);
    pending_points.push_back(mk_point(300, -300, 17, 17, 2, -4, 16383, 1));
    pending_points.push_back(mk_point(300, -300, 17, 17, -4194304, 4194304, 0, 0));
    drain();
    write_qp(1);
    pending_points.push_back(mk_point(9999, 1, 2, 3, 4194303, 1, 0, 0));
    pending_points.push_back(mk_point(9999, 1, 2, 3, 4194303, 1, 1, 1));

    run_phase(0, 180);
    run_phase(MaxPoints, 180);
    run_phase(32767, 150);
    run_phase($urandom_range(1, 64), 180);
    run_phase($urandom_range(65, MaxPoints - 1), 180);
    drain();
    no_idle = 1'b1;
    run_phase(8, 200);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legitimate run
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ reference_phase_magnitude_correction.f @@
rtl/rpmc_pkg.sv
rtl/rpmc_front.sv
rtl/rpmc_sqrt.sv
rtl/rpmc_div.sv
rtl/reference_phase_magnitude_correction.sv
bench/testbench.sv
